/* src/ttmmf_pkg.sv */
// Shared types and constants for the three-tap min/max filter.
`timescale 1ns / 1ps
`default_nettype none

package ttmmf_pkg;

    localparam int PIXEL_W        = 8;
    localparam int LINE_WIDTH_W   = 13;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int ROW_W          = 16;

    // APB register file: four 32-bit registers at byte offsets 0, 4, 8, 12
    localparam int APB_DATA_W = 32;
    localparam int REG_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_USE_MAX      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_VERTICAL     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 13'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    typedef struct packed {
        logic [PIXEL_W-1:0] filtered;
        logic               end_of_row;
        logic               end_of_frame;
        logic               last_of_run;
    } res_t;

endpackage

`default_nettype wire

/* src/ttmmf_pix_if.sv */
// Pixel input channel: valid/ready handshake carrying one pixel request.
`timescale 1ns / 1ps
`default_nettype none

interface ttmmf_pix_if;
    logic                             valid;
    logic                             ready;
    logic [ttmmf_pkg::PIXEL_W-1:0]    pixel;
    logic                             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

/* src/ttmmf_res_if.sv */
// Result output channel: valid/ready handshake carrying one filtered pixel request.
`timescale 1ns / 1ps
`default_nettype none

interface ttmmf_res_if;
    logic                             valid;
    logic                             ready;
    logic [ttmmf_pkg::PIXEL_W-1:0]    filtered;
    logic                             end_of_row;
    logic                             end_of_frame;
    logic                             last_of_run;

    modport source (output valid, output filtered, output end_of_row,
                    output end_of_frame, output last_of_run, input ready);
    modport sink   (input valid, input filtered, input end_of_row,
                    input end_of_frame, input last_of_run, output ready);
endinterface

`default_nettype wire

/* src/ttmmf_line_store.sv */
// One line buffer: single-port write, registered read with same-cycle write bypass.
`timescale 1ns / 1ps
`default_nettype none

module ttmmf_line_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [ttmmf_pkg::PIXEL_W-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [ADDR_W-1:0]             rd_addr,
    output logic      [ttmmf_pkg::PIXEL_W-1:0] rd_data
);
    import ttmmf_pkg::*;

    logic [PIXEL_W-1:0] mem_reg [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // write-first on a collision: narrow frames hit the same column back to back
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/ttmmf_res_fifo.sv */
// Two-entry result queue driving the output channel; full flag is register-based.
`timescale 1ns / 1ps
`default_nettype none

module ttmmf_res_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ttmmf_pkg::res_t push_data,
    output logic                 full,
    ttmmf_res_if.source          res_out
);
    import ttmmf_pkg::*;

    localparam int DEPTH = 2;

    res_t       ent_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    res_t       head;

    assign pop  = res_out.valid && res_out.ready;
    assign full = (count_reg == 2'(DEPTH));
    assign head = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign res_out.valid        = (count_reg != 2'd0);
    assign res_out.filtered     = head.filtered;
    assign res_out.end_of_row   = head.end_of_row;
    assign res_out.end_of_frame = head.end_of_frame;
    assign res_out.last_of_run  = head.last_of_run;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'(DEPTH)))
        else $error("result queue overflow");

    a_fill_from_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (count_reg == 2'd0)) |=> (count_reg == 2'd1))
        else $error("push into empty queue lost");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && !res_out.ready && !push) |=> $stable(count_reg))
        else $error("queue occupancy changed while stalled");

endmodule

`default_nettype wire

/* src/three_tap_min_max_filter_core.sv */
// Three-tap grayscale dilation/erosion filter (3x1 or 1x3 min/max), top level.
//
// Pixels arrive in raster order on pix_in (valid/ready); frame_start on a
// request clears the column and row counters before that pixel is used.
// Results leave on res_out (valid/ready). Each pixel yields zero, one or two
// result requests; last_of_run marks the final one belonging to that pixel.
// use_max picks max (dilation) or min (erosion); vertical picks the column
// direction, which looks up two line buffers, else the row direction.
// Horizontal output lags one pixel, vertical output lags one row; the last
// pixel of a row (horizontal) or any pixel of the last row (vertical) also
// flushes the edge result over a two-tap window.
// Path: a result goes from the working stage register into the result queue
// and on to res_out. Throughput: one pixel per clock while the queue has room;
// a pixel with two results holds the working stage until both are written
// (one queue write per clock). A two-entry result queue sits in front of
// res_out, so a receiver stall does not reach pix_in.ready until it fills.
// Reset: config takes its default values, counters and pixel history
// clear. Line buffers are not cleared; entries are written before use.
// Config registers (APB, 32-bit): 0x0 use_max, 0x4 vertical,
// 0x8 line_width, 0xC frame_height. Write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module three_tap_min_max_filter_core #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ttmmf_pkg::REG_ADDR_W-1:0]    paddr,
    input  wire logic [ttmmf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ttmmf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready,
    ttmmf_pix_if.sink                                pix_in,
    ttmmf_res_if.source                              res_out
);
    import ttmmf_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    // compare width that holds both the width register and MAX_LINE_WIDTH
    localparam int EXT_W = (COL_W + 1 > LINE_WIDTH_W) ? COL_W + 1 : LINE_WIDTH_W;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [COL_W-1:0]   idx;
        logic               last_col;
        logic               last_row;
        logic               col_zero;
        logic               col_one;
        logic               row_zero;
        logic               row_one;
    } stage_t;

    function automatic logic [PIXEL_W-1:0] pick2(input logic mx,
                                                 input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b);
        logic a_gt;
        a_gt = (a > b);
        if (mx)
        begin
            return a_gt ? a : b;
        end
        return a_gt ? b : a;
    endfunction

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic                      use_max_reg;
    logic                      vertical_reg;
    logic [LINE_WIDTH_W-1:0]   line_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[REG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_max_reg      <= 1'b1;
            vertical_reg     <= 1'b0;
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_USE_MAX:      use_max_reg      <= pwdata[0];
                REG_VERTICAL:     vertical_reg     <= pwdata[0];
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[LINE_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FRAME_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_USE_MAX:      prdata = APB_DATA_W'(use_max_reg);
            REG_VERTICAL:     prdata = APB_DATA_W'(vertical_reg);
            REG_LINE_WIDTH:   prdata = APB_DATA_W'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Geometry: clamp width to [1, MAX_LINE_WIDTH], height to >= 1
    // ---------------------------------------------------------------
    logic [EXT_W-1:0]          lw_ext;
    logic [EXT_W-1:0]          w_eff;
    logic [FRAME_HEIGHT_W-1:0] h_eff;
    logic                      w_is1;
    logic                      h_is1;

    always_comb
    begin
        lw_ext = EXT_W'(line_width_reg);
        if (lw_ext == '0)
        begin
            w_eff = EXT_W'(1);
        end
        else if (lw_ext > EXT_W'(MAX_LINE_WIDTH))
        begin
            w_eff = EXT_W'(MAX_LINE_WIDTH);
        end
        else
        begin
            w_eff = lw_ext;
        end
        h_eff = (frame_height_reg == '0) ? FRAME_HEIGHT_W'(1) : frame_height_reg;
        w_is1 = (w_eff == EXT_W'(1));
        h_is1 = (h_eff == FRAME_HEIGHT_W'(1));
    end

    // ---------------------------------------------------------------
    // Accept side: position counters and line buffer read
    // ---------------------------------------------------------------
    logic             accept;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             last_col;
    logic             last_row;
    stage_t           s1_next;

    assign accept = pix_in.valid && pix_in.ready;

    always_comb
    begin
        col_cur  = pix_in.frame_start ? '0 : col_reg;
        row_cur  = pix_in.frame_start ? '0 : row_reg;
        last_col = (EXT_W'(col_cur) >= (w_eff - EXT_W'(1)));
        last_row = (row_cur >= (h_eff - FRAME_HEIGHT_W'(1)));
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : (row_cur + ROW_W'(1));
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end

        s1_next.pixel    = pix_in.pixel;
        s1_next.idx      = col_cur;
        s1_next.last_col = last_col;
        s1_next.last_row = last_row;
        s1_next.col_zero = (col_cur == '0);
        s1_next.col_one  = (col_cur == COL_W'(1));
        s1_next.row_zero = (row_cur == '0);
        s1_next.row_one  = (row_cur == ROW_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // Working stage: one pixel, its line buffer taps and pixel history
    // ---------------------------------------------------------------
    stage_t             s1_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               phase_reg;      // 1: second result of this pixel is next
    logic               phase_next;
    logic               s1_done;
    logic               emit;
    logic               fifo_full;
    logic [PIXEL_W-1:0] prev_reg;
    logic [PIXEL_W-1:0] prev2_reg;
    logic [PIXEL_W-1:0] a1;
    logic [PIXEL_W-1:0] a2;
    logic               has_res;
    logic               two_res;
    res_t               r0;
    res_t               r1;
    res_t               emit_data;

    ttmmf_line_store #(
        .DEPTH  (MAX_LINE_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_one (
        .clk     (clk),
        .wr_en   (s1_done),
        .wr_addr (s1_reg.idx),
        .wr_data (s1_reg.pixel),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (a1)
    );

    // the row two above takes what was one above at this column
    ttmmf_line_store #(
        .DEPTH  (MAX_LINE_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_two (
        .clk     (clk),
        .wr_en   (s1_done),
        .wr_addr (s1_reg.idx),
        .wr_data (a1),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (a2)
    );

    always_comb
    begin
        has_res = 1'b0;
        two_res = 1'b0;
        r0      = '0;
        r1      = '0;
        if (!vertical_reg)
        begin
            if (w_is1)
            begin
                has_res = 1'b1;
                r0      = '{s1_reg.pixel, 1'b1, s1_reg.last_row, 1'b1};
            end
            else if (!s1_reg.col_zero)
            begin
                has_res        = 1'b1;
                two_res        = s1_reg.last_col;
                r0.filtered    = s1_reg.col_one
                                 ? pick2(use_max_reg, prev_reg, s1_reg.pixel)
                                 : pick2(use_max_reg,
                                         pick2(use_max_reg, prev2_reg, prev_reg),
                                         s1_reg.pixel);
                r0.last_of_run = !s1_reg.last_col;
                r1 = '{pick2(use_max_reg, prev_reg, s1_reg.pixel), 1'b1,
                       s1_reg.last_row, 1'b1};
            end
        end
        else
        begin
            if (h_is1)
            begin
                has_res = 1'b1;
                r0      = '{s1_reg.pixel, s1_reg.last_col, s1_reg.last_col, 1'b1};
            end
            else if (!s1_reg.row_zero)
            begin
                has_res         = 1'b1;
                two_res         = s1_reg.last_row;
                r0.filtered     = s1_reg.row_one
                                  ? pick2(use_max_reg, a1, s1_reg.pixel)
                                  : pick2(use_max_reg, pick2(use_max_reg, a2, a1),
                                          s1_reg.pixel);
                r0.end_of_row   = s1_reg.last_col;
                r0.last_of_run  = !s1_reg.last_row;
                r1 = '{pick2(use_max_reg, a1, s1_reg.pixel), s1_reg.last_col,
                       s1_reg.last_col, 1'b1};
            end
        end
    end

    always_comb
    begin
        emit      = s1_valid_reg && has_res && !fifo_full;
        s1_done   = s1_valid_reg
                    && (!has_res || (!fifo_full && (!two_res || phase_reg)));
        emit_data = phase_reg ? r1 : r0;

        if (s1_done)
        begin
            phase_next = 1'b0;
        end
        else if (emit)
        begin
            phase_next = 1'b1;
        end
        else
        begin
            phase_next = phase_reg;
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // a new pixel enters when the working stage is empty or empties this cycle
    assign pix_in.ready = !s1_valid_reg || s1_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            prev_reg     <= '0;
            prev2_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            phase_reg    <= phase_next;
            if (s1_done)
            begin
                prev2_reg <= prev_reg;
                prev_reg  <= s1_reg.pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    ttmmf_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (emit_data),
        .full      (fifo_full),
        .res_out   (res_out)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !s1_done) |=> (s1_valid_reg && phase_reg))
        else $error("edge flush result dropped");

    a_final_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && s1_done) |-> emit_data.last_of_run)
        else $error("final result of a pixel lacks last_of_run");

    a_first_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !s1_done) |-> !emit_data.last_of_run)
        else $error("first of two results carries last_of_run");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(MAX_LINE_WIDTH - 1))
        else $error("column counter beyond line buffer depth");

endmodule

`default_nettype wire

/* verif/three_tap_min_max_filter_core_tb.sv */
// Self-checking testbench for the three-tap min/max filter core.
`timescale 1ns / 1ps

module three_tap_min_max_filter_core_tb;
    import ttmmf_pkg::*;

    localparam int MAX_W        = 4096;   // line store depth of the block
    localparam int DRAIN_CYCLES = 6;      // working stage register plus the result queue
    localparam int CYCLE_LIMIT  = 400000;
    localparam res_t NO_RES     = '0;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    // One row of the directed table: a register write or a pixel request.
    // typed = 1 means the n_typed results are given here; otherwise the
    // filter model below supplies them.
    typedef struct packed {
        row_kind_e              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [15:0]            value;
        logic [PIXEL_W-1:0]     px;
        logic                   fs;
        logic                   typed;
        logic [1:0]             n_typed;
        res_t                   r0;
        res_t                   r1;
    } stim_row_t;

    // Directed part: max then min across a 3x2 frame, width one and width
    // zero pass-through, a 2x3 vertical frame, and height zero / one
    // pass-through in vertical mode.
    localparam stim_row_t DIRECTED [32] = '{
        '{ROW_CFG, REG_LINE_WIDTH, 16'd3, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, REG_FRAME_HEIGHT, 16'd2, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // row 0: first pixel gives nothing, last pixel flushes the edge
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h00, 1'b1, 1'b1, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'hFF, 1'b0, 1'b1, 2'd1,
          '{8'hFF, 1'b0, 1'b0, 1'b1}, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h10, 1'b0, 1'b1, 2'd2,
          '{8'hFF, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b0, 1'b1}},
        // row 1 is the last row: flush result carries end of frame
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h80, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h7F, 1'b0, 1'b1, 2'd1,
          '{8'h80, 1'b0, 1'b0, 1'b1}, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h01, 1'b0, 1'b1, 2'd2,
          '{8'h80, 1'b0, 1'b0, 1'b0}, '{8'h7F, 1'b1, 1'b1, 1'b1}},
        // erosion
        '{ROW_CFG, REG_USE_MAX, 16'd0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'hFF, 1'b1, 1'b1, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h00, 1'b0, 1'b1, 2'd1,
          '{8'h00, 1'b0, 1'b0, 1'b1}, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'hFF, 1'b0, 1'b1, 2'd2,
          '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0, 1'b1}},
        // width one: straight through, every pixel ends its row
        '{ROW_CFG, REG_LINE_WIDTH, 16'd1, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'hAA, 1'b1, 1'b1, 2'd1,
          '{8'hAA, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h55, 1'b0, 1'b1, 2'd1,
          '{8'h55, 1'b1, 1'b1, 1'b1}, NO_RES},
        // width zero counts as one
        '{ROW_CFG, REG_LINE_WIDTH, 16'd0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h5A, 1'b1, 1'b1, 2'd1,
          '{8'h5A, 1'b1, 1'b0, 1'b1}, NO_RES},
        // vertical 2x3 dilation, checked by the model
        '{ROW_CFG, REG_VERTICAL, 16'd1, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, REG_LINE_WIDTH, 16'd2, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, REG_FRAME_HEIGHT, 16'd3, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, REG_USE_MAX, 16'd1, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h10, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h20, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h30, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h05, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // height zero counts as one: vertical pass-through
        '{ROW_CFG, REG_FRAME_HEIGHT, 16'd0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h33, 1'b1, 1'b1, 2'd1,
          '{8'h33, 1'b0, 1'b0, 1'b1}, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'hCC, 1'b0, 1'b1, 2'd1,
          '{8'hCC, 1'b1, 1'b1, 1'b1}, NO_RES},
        '{ROW_CFG, REG_FRAME_HEIGHT, 16'd1, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_PIX, REG_USE_MAX, 16'd0, 8'h00, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ttmmf_pix_if pix_if ();
    ttmmf_res_if res_if ();

    three_tap_min_max_filter_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_if),
        .res_out (res_if)
    );

    // ------------------------------------------------------------------
    // Filter model: own copy of the registers, line stores, pixel history
    // and raster position. Advanced once per accepted pixel request.
    // ------------------------------------------------------------------
    logic                      cfg_use_max  = 1'b1;
    logic                      cfg_vertical = 1'b0;
    logic [LINE_WIDTH_W-1:0]   cfg_width    = LINE_WIDTH_RST;
    logic [FRAME_HEIGHT_W-1:0] cfg_height   = FRAME_HEIGHT_RST;

    logic [PIXEL_W-1:0] line_above1 [MAX_W];
    logic [PIXEL_W-1:0] line_above2 [MAX_W];
    logic [PIXEL_W-1:0] prev_px  = '0;
    logic [PIXEL_W-1:0] prev2_px = '0;
    logic [11:0]        col_pos  = '0;
    logic [ROW_W-1:0]   row_pos  = '0;

    res_t filter_out [2];      // results of the latest pixel
    int   filter_out_count;

    res_t       pending_results [$];   // results still owed by the block
    int         error_count = 0;
    int         cycle_count = 0;
    idle_mode_e idle_mode   = IDLE_NONE;

    function automatic logic [PIXEL_W-1:0] pick_two(input logic [PIXEL_W-1:0] a,
                                                    input logic [PIXEL_W-1:0] b);
        if (cfg_use_max)
            return (a > b) ? a : b;
        return (a < b) ? a : b;
    endfunction

    task automatic emit(input logic [PIXEL_W-1:0] v, input logic eor, input logic eof,
                        input logic last);
        filter_out[filter_out_count] = '{v, eor, eof, last};
        filter_out_count++;
    endtask

    task automatic filter_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
        int unsigned        w;
        int unsigned        h;
        int unsigned        col;
        int unsigned        row;
        logic               last_col;
        logic               last_row;
        logic [PIXEL_W-1:0] a1;
        logic [PIXEL_W-1:0] a2;
        w = cfg_width;
        h = cfg_height;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (h < 1) h = 1;
        if (fs)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        col = col_pos;
        row = row_pos;
        last_col = (col >= w - 1);
        last_row = (row >= h - 1);
        a1 = line_above1[col];
        a2 = line_above2[col];
        filter_out_count = 0;
        if (!cfg_vertical)
        begin
            if (w == 1)
                emit(px, 1'b1, last_row, 1'b1);
            else if (col != 0)
            begin
                // second column sees only a two-pixel window on the left edge
                emit((col == 1) ? pick_two(prev_px, px)
                                : pick_two(pick_two(prev2_px, prev_px), px),
                     1'b0, 1'b0, !last_col);
                if (last_col)
                    emit(pick_two(prev_px, px), 1'b1, last_row, 1'b1);
            end
        end
        else
        begin
            if (h == 1)
                emit(px, last_col, last_col, 1'b1);
            else if (row != 0)
            begin
                emit((row == 1) ? pick_two(a1, px) : pick_two(pick_two(a2, a1), px),
                     last_col, 1'b0, !last_row);
                if (last_row)
                    emit(pick_two(a1, px), last_col, last_col, 1'b1);
            end
        end
        // stores and history move in both modes
        line_above2[col] = a1;
        line_above1[col] = px;
        prev2_px = prev_px;
        prev_px = px;
        if (last_col)
        begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------
    function automatic bit sender_pause();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 70;
            IDLE_BOTH:   return $urandom_range(0, 99) < 32;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 70;
            IDLE_BOTH:     return $urandom_range(0, 99) < 32;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything changes with nonblocking assignments right after
    // a rising edge; handshakes are judged on pre-edge values.
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic fs, input logic typed,
                              input logic [1:0] n_typed, input res_t t0, input res_t t1);
        while (sender_pause())
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= px;
        pix_if.frame_start <= fs;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        // accepted here; its results pass the working stage, then the result queue
        filter_pixel(px, fs);
        if (typed)
        begin
            if (n_typed >= 1) pending_results.push_back(t0);
            if (n_typed >= 2) pending_results.push_back(t1);
        end
        else
            for (int i = 0; i < filter_out_count; i++)
                pending_results.push_back(filter_out[i]);
    endtask

    // Block idle: nothing owed, and a pixel with no result has had time to retire.
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write, then read back from the same address with psel held high.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] mask;
        case (idx)
            REG_USE_MAX, REG_VERTICAL: mask = 32'h1;
            REG_LINE_WIDTH:            mask = 32'h1FFF;
            default:                   mask = 32'hFFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_USE_MAX:    cfg_use_max  = value[0];
            REG_VERTICAL:   cfg_vertical = value[0];
            REG_LINE_WIDTH: cfg_width    = value[LINE_WIDTH_W-1:0];
            default:        cfg_height   = value[FRAME_HEIGHT_W-1:0];
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== (value & mask))
            report_mismatch($sformatf("register %0d reads %h, wrote %h",
                                      idx, prdata, value & mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver, result check, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= !receiver_stall();
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h eor %b eof %b last %b",
                                          res_if.filtered, res_if.end_of_row,
                                          res_if.end_of_frame, res_if.last_of_run));
            else
            begin
                want = pending_results.pop_front();
                if (res_if.filtered !== want.filtered)
                    report_mismatch($sformatf("filtered %h, want %h",
                                              res_if.filtered, want.filtered));
                if (res_if.end_of_row !== want.end_of_row)
                    report_mismatch($sformatf("end_of_row %b, want %b",
                                              res_if.end_of_row, want.end_of_row));
                if (res_if.end_of_frame !== want.end_of_frame)
                    report_mismatch($sformatf("end_of_frame %b, want %b",
                                              res_if.end_of_frame, want.end_of_frame));
                if (res_if.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              res_if.last_of_run, want.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int n_items;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel       <= '0;
        pix_if.frame_start <= 1'b0;
        rst_n              <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_register(DIRECTED[i].idx, APB_DATA_W'(DIRECTED[i].value));
            end
            else
                send_pixel(DIRECTED[i].px, DIRECTED[i].fs, DIRECTED[i].typed,
                           DIRECTED[i].n_typed, DIRECTED[i].r0, DIRECTED[i].r1);
        end

        // random phases: small frames, each opened by frame_start, with the
        // odd early frame_start to break a frame off mid-way
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            idle_mode = idle_mode_e'(ph % 4);
            write_register(REG_USE_MAX, $urandom_range(0, 1));
            write_register(REG_VERTICAL, $urandom_range(0, 1));
            case ($urandom_range(0, 19))
                0, 1:    write_register(REG_LINE_WIDTH, 0);
                2, 3:    write_register(REG_LINE_WIDTH, 1);
                4:       write_register(REG_LINE_WIDTH, 32'h1FFF);  // clamps to MAX_W
                5, 6, 7: write_register(REG_LINE_WIDTH, $urandom_range(7, 40));
                default: write_register(REG_LINE_WIDTH, $urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 19))
                0, 1:    write_register(REG_FRAME_HEIGHT, 0);
                2, 3:    write_register(REG_FRAME_HEIGHT, 1);
                4:       write_register(REG_FRAME_HEIGHT, 32'hFFFF);
                default: write_register(REG_FRAME_HEIGHT, $urandom_range(2, 6));
            endcase
            n_items = $urandom_range(55, 85);
            for (int k = 0; k < n_items; k++)
                send_pixel(rand_pixel(), (k == 0) || ($urandom_range(0, 99) < 3),
                           1'b0, 2'd0, NO_RES, NO_RES);
        end

        wait_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
